### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock and reset are taken from the
// scope of the module that uses them (clk, rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define VMDC_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("vmdc: assertion failed");

// Check that a condition on one edge implies another on the next edge.
`define VMDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vmdc: assertion failed");

`else

`define VMDC_ASSERT(label, cond)
`define VMDC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/vmdc_pkg.sv
`timescale 1ns / 1ps

package vmdc_pkg;

  // Default component width: signed Q8.8
  localparam int COMPONENT_WIDTH_DEF = 16;

endpackage

### rtl/vector3_magnitude_dot_cross_top.sv
`timescale 1ns / 1ps
// Channel  | Dir | Words                 | Fields (lowest bit first)
// ---------+-----+-----------------------+-------------------------------------------
// in_      | in  | one vector pair       | ax ay az bx by bz
// out_     | out | one result per pair   | mag_a mag_b sum_x sum_y sum_z dot
//          |     |                       | cross_x cross_y cross_z
//
// Throughput is one word per cycle while out_tready does not stall the output;
// the pipeline is one multiply stage, one add stage, then one stage per root
// bit of the two square-root lanes.
// rst_n clears only the stage valid bits; the datapath registers are not reset.
// Each stage loads when it is empty or its successor moves, so bubbles fill
// and a stall at out_tready backs up stage by stage.

`include "assert_macros.svh"

module vector3_magnitude_dot_cross_top
  import vmdc_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // ax, ay, az, bx, by, bz (COMPONENT_WIDTH each), zero padded to bytes
  input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // mag_a, mag_b, sum_x, sum_y, sum_z, dot, cross_x, cross_y, cross_z,
  // zero padded to bytes
  output logic [((2*COMPONENT_WIDTH + 3*(COMPONENT_WIDTH+1)
                  + ((2*COMPONENT_WIDTH+1 > 64) ? 64 : 2*COMPONENT_WIDTH+1)
                  + 6*COMPONENT_WIDTH + 7)/8)*8-1:0] out_tdata
);

  localparam int W      = COMPONENT_WIDTH;
  localparam int SW     = W + 1;
  localparam int PW     = 2 * W;
  localparam int DF     = 2 * W + 1;
  localparam int DOT_W  = (DF > 64) ? 64 : DF;
  localparam int SQ_W   = 2 * W;
  localparam int RW     = SQ_W + 1;
  localparam int NS     = W + 2;
  localparam int OUT_TW = ((2*W + 3*SW + DOT_W + 6*W + 7)/8)*8;

  // Stage valid bits and load enables
  logic [NS-1:0] vld_r, vld_nxt, en;

  // Multiply stage registers
  logic signed [PW-1:0] p_aa_r [3];
  logic signed [PW-1:0] p_bb_r [3];
  logic signed [PW-1:0] p_dt_r [3];
  logic signed [PW-1:0] p_cr_r [6];
  logic signed [SW-1:0] sum_p_r [3];

  // Add and root stages, index 0 is the add stage
  logic [SQ_W-1:0]      rem_a_r  [W+1];
  logic [SQ_W-1:0]      rem_b_r  [W+1];
  logic [W-1:0]         root_a_r [W+1];
  logic [W-1:0]         root_b_r [W+1];
  logic signed [SW-1:0] sum_r    [W+1][3];
  logic [DOT_W-1:0]     dot_r    [W+1];
  logic signed [PW-1:0] crs_r    [W+1][3];

  logic signed [W-1:0] ax, ay, az, bx, by, bz;
  logic signed [DF-1:0] dot_full;
  logic in_acc, out_acc;

  assign ax = in_tdata[0*W +: W];
  assign ay = in_tdata[1*W +: W];
  assign az = in_tdata[2*W +: W];
  assign bx = in_tdata[3*W +: W];
  assign by = in_tdata[4*W +: W];
  assign bz = in_tdata[5*W +: W];

  // Load a stage when it is empty or its successor moves
  always_comb begin
    en[NS-1] = ~vld_r[NS-1] | out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld_r[k] | en[k+1];
    end
    vld_nxt[0] = en[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NS-1];
  assign in_acc     = in_tvalid & in_tready;
  assign out_acc    = out_tvalid & out_tready;

  // Multiply stage: squares, dot terms, cross terms and sums
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_aa_r[0] <= ax * ax;
      p_aa_r[1] <= ay * ay;
      p_aa_r[2] <= az * az;
      p_bb_r[0] <= bx * bx;
      p_bb_r[1] <= by * by;
      p_bb_r[2] <= bz * bz;
      p_dt_r[0] <= ax * bx;
      p_dt_r[1] <= ay * by;
      p_dt_r[2] <= az * bz;
      p_cr_r[0] <= ay * bz;
      p_cr_r[1] <= az * by;
      p_cr_r[2] <= az * bx;
      p_cr_r[3] <= ax * bz;
      p_cr_r[4] <= ax * by;
      p_cr_r[5] <= ay * bx;
      sum_p_r[0] <= SW'(ax) + SW'(bx);
      sum_p_r[1] <= SW'(ay) + SW'(by);
      sum_p_r[2] <= SW'(az) + SW'(bz);
    end
  end

  // Add stage: squared lengths, dot product, cross differences
  assign dot_full = DF'(p_dt_r[0]) + DF'(p_dt_r[1]) + DF'(p_dt_r[2]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem_a_r[0]  <= $unsigned(p_aa_r[0]) + $unsigned(p_aa_r[1]) + $unsigned(p_aa_r[2]);
      rem_b_r[0]  <= $unsigned(p_bb_r[0]) + $unsigned(p_bb_r[1]) + $unsigned(p_bb_r[2]);
      root_a_r[0] <= '0;
      root_b_r[0] <= '0;
      sum_r[0]    <= sum_p_r;
      dot_r[0]    <= dot_full[DOT_W-1:0];
      crs_r[0][0] <= p_cr_r[0] - p_cr_r[1];
      crs_r[0][1] <= p_cr_r[2] - p_cr_r[3];
      crs_r[0][2] <= p_cr_r[4] - p_cr_r[5];
    end
  end

  // Root stages: settle one root bit per stage, most significant first
  for (genvar j = 1; j <= W; j++) begin : g_root
    localparam int K = W - j;
    logic [RW-1:0] trial_a, trial_b;
    logic          take_a, take_b;

    assign trial_a = (RW'(root_a_r[j-1]) << (K + 1)) | (RW'(1) << (2 * K));
    assign trial_b = (RW'(root_b_r[j-1]) << (K + 1)) | (RW'(1) << (2 * K));
    assign take_a  = {1'b0, rem_a_r[j-1]} >= trial_a;
    assign take_b  = {1'b0, rem_b_r[j-1]} >= trial_b;

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        rem_a_r[j]  <= take_a ? rem_a_r[j-1] - trial_a[SQ_W-1:0] : rem_a_r[j-1];
        rem_b_r[j]  <= take_b ? rem_b_r[j-1] - trial_b[SQ_W-1:0] : rem_b_r[j-1];
        root_a_r[j] <= take_a ? root_a_r[j-1] | (W'(1) << K) : root_a_r[j-1];
        root_b_r[j] <= take_b ? root_b_r[j-1] | (W'(1) << K) : root_b_r[j-1];
        sum_r[j]    <= sum_r[j-1];
        dot_r[j]    <= dot_r[j-1];
        crs_r[j]    <= crs_r[j-1];
      end
    end
  end

  // Pack the result word
  assign out_tdata = OUT_TW'({crs_r[W][2], crs_r[W][1], crs_r[W][0], dot_r[W],
                              sum_r[W][2], sum_r[W][1], sum_r[W][0],
                              root_b_r[W], root_a_r[W]});

  // Words in flight change only by accepted and delivered words
  `VMDC_ASSERT(a_occupancy,
    ($countones(vld_nxt) + int'(out_acc)) == ($countones(vld_r) + int'(in_acc)))
  // Input backs off only when every stage is full
  `VMDC_ASSERT(a_full_when_blocked, in_tready || (&vld_r))
  // An accepted word lands in the multiply stage
  `VMDC_ASSERT_NEXT(a_accept_lands, in_acc, vld_r[0])
  // Final remainders stay within the floor-root bound
  `VMDC_ASSERT(a_root_a_floor,
    !out_tvalid || ({1'b0, rem_a_r[W]} <= ({1'b0, RW'(root_a_r[W])} << 1)))
  `VMDC_ASSERT(a_root_b_floor,
    !out_tvalid || ({1'b0, rem_b_r[W]} <= ({1'b0, RW'(root_b_r[W])} << 1)))

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import vmdc_pkg::*;
();

  localparam int CW         = COMPONENT_WIDTH_DEF;
  localparam int IN_BITS    = ((6*CW + 7)/8)*8;
  localparam int DOT_W      = (2*CW + 1 > 64) ? 64 : 2*CW + 1;
  localparam int FIELD_BITS = 2*CW + 3*(CW + 1) + DOT_W + 6*CW;
  localparam int OUT_BITS   = ((FIELD_BITS + 7)/8)*8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 3*(CW + 2);
  localparam logic signed [CW-1:0] COMP_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COMP_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE      = CW'(256);

  typedef struct {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
  } vec_pair_t;

  typedef struct {
    logic [CW-1:0]          mag_a, mag_b;
    logic signed [CW:0]     sum_x, sum_y, sum_z;
    logic signed [DOT_W-1:0] dot;
    logic signed [2*CW-1:0] cross_x, cross_y, cross_z;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;

  vec_result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  bit idle_enable = 1'b1;

  vector3_magnitude_dot_cross_top #(
    .COMPONENT_WIDTH(CW)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= !idle_enable || ($urandom_range(99) >= 19);
  end

  // Floor square root, one result bit at a time from the top
  function automatic logic [CW-1:0] floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    for (int b = CW - 1; b >= 0; b--) begin
      probe = root | (64'd1 << b);
      if (probe * probe <= n) root = probe;
    end
    return root[CW-1:0];
  endfunction

  function automatic vec_result_t predict_vector_result(vec_pair_t p);
    vec_result_t r;
    longint ax, ay, az, bx, by, bz;
    ax = p.ax; ay = p.ay; az = p.az;
    bx = p.bx; by = p.by; bz = p.bz;
    r.mag_a   = floor_root(ax*ax + ay*ay + az*az);
    r.mag_b   = floor_root(bx*bx + by*by + bz*bz);
    r.sum_x   = (CW+1)'(ax + bx);
    r.sum_y   = (CW+1)'(ay + by);
    r.sum_z   = (CW+1)'(az + bz);
    r.dot     = DOT_W'(ax*bx + ay*by + az*bz);
    r.cross_x = (2*CW)'(ay*bz - az*by);
    r.cross_y = (2*CW)'(az*bx - ax*bz);
    r.cross_z = (2*CW)'(ax*by - ay*bx);
    return r;
  endfunction

  function automatic vec_pair_t make_pair(logic signed [CW-1:0] ax, ay, az, bx, by, bz);
    vec_pair_t p;
    p.ax = ax; p.ay = ay; p.az = az;
    p.bx = bx; p.by = by; p.bz = bz;
    return p;
  endfunction

  // Mostly full-range values, with extremes and small magnitudes mixed in
  function automatic logic signed [CW-1:0] random_component();
    case ($urandom_range(9))
      0: return COMP_MIN;
      1: return COMP_MAX;
      2: return CW'(int'($urandom_range(1023)) - 512);
      default: return CW'($urandom());
    endcase
  endfunction

  function automatic vec_pair_t random_pair();
    return make_pair(random_component(), random_component(), random_component(),
                     random_component(), random_component(), random_component());
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    vec_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("mag_a",   64'(e.mag_a),              64'(out_tdata[15:0]));
        check_field("mag_b",   64'(e.mag_b),              64'(out_tdata[31:16]));
        check_field("sum_x",   64'($unsigned(e.sum_x)),   64'(out_tdata[48:32]));
        check_field("sum_y",   64'($unsigned(e.sum_y)),   64'(out_tdata[65:49]));
        check_field("sum_z",   64'($unsigned(e.sum_z)),   64'(out_tdata[82:66]));
        check_field("dot",     64'($unsigned(e.dot)),     64'(out_tdata[115:83]));
        check_field("cross_x", 64'($unsigned(e.cross_x)), 64'(out_tdata[147:116]));
        check_field("cross_y", 64'($unsigned(e.cross_y)), 64'(out_tdata[179:148]));
        check_field("cross_z", 64'($unsigned(e.cross_z)), 64'(out_tdata[211:180]));
        check_field("padding", 64'd0,                     64'(out_tdata[OUT_BITS-1:FIELD_BITS]));
      end
    end
  end

  // Send one vector pair word; hold it until accepted
  task automatic send_vector_pair(vec_pair_t p);
    while (idle_enable && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.bz, p.by, p.bx, p.az, p.ay, p.ax};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_vector_result(p));
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_zero_and_units();
    send_vector_pair(make_pair(0, 0, 0, 0, 0, 0));
    send_vector_pair(make_pair(ONE, 0, 0, 0, ONE, 0));
    send_vector_pair(make_pair(0, ONE, 0, 0, 0, ONE));
    send_vector_pair(make_pair(0, 0, ONE, ONE, 0, 0));
    send_vector_pair(make_pair(-ONE, 0, 0, 0, -ONE, 0));
  endtask

  task automatic test_extremes();
    // largest sums, dot at both ends
    send_vector_pair(make_pair(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
    send_vector_pair(make_pair(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_vector_pair(make_pair(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MAX, COMP_MAX, COMP_MAX));
    send_vector_pair(make_pair(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN));
    // each cross component at its positive and negative limit
    send_vector_pair(make_pair(0, COMP_MIN, COMP_MAX, 0, COMP_MIN, COMP_MIN));
    send_vector_pair(make_pair(0, COMP_MIN, COMP_MIN, 0, COMP_MIN, COMP_MAX));
    send_vector_pair(make_pair(COMP_MIN, 0, COMP_MIN, COMP_MIN, 0, COMP_MAX));
    send_vector_pair(make_pair(COMP_MIN, 0, COMP_MAX, COMP_MIN, 0, COMP_MIN));
    send_vector_pair(make_pair(COMP_MIN, COMP_MIN, 0, COMP_MAX, COMP_MIN, 0));
    send_vector_pair(make_pair(COMP_MAX, COMP_MIN, 0, COMP_MIN, COMP_MIN, 0));
  endtask

  task automatic test_square_roots();
    // exact roots and values just off them
    send_vector_pair(make_pair(768, 1024, 0, 0, -1024, -768));
    send_vector_pair(make_pair(1, 1, 1, 2, 1, 0));
    send_vector_pair(make_pair(-3, 0, 0, 0, 0, 2));
    send_vector_pair(make_pair(512, 512, 256, 511, 512, 256));
    send_vector_pair(make_pair(1, 0, 0, 0, 0, -1));
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    repeat (120) send_vector_pair(random_pair());
    idle_enable = 1'b1;
  endtask

  task automatic test_random_stream();
    repeat (300) send_vector_pair(random_pair());
  endtask

  task automatic test_drain_pause();
    repeat (60) send_vector_pair(random_pair());
    wait_for_drain();
    repeat (60) send_vector_pair(random_pair());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_and_units();
    test_extremes();
    test_square_roots();
    test_back_to_back();
    test_random_stream();
    test_drain_pause();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
